/* hw/rtl/cbfd_pkg.sv */
// Shared constants, types and helpers for the cubic Bezier forward differencer.
`default_nettype none

package cbfd_pkg;

  // Point count limits and fixed field widths
  localparam int MAX_POINTS = 64;
  localparam int CNT_W      = 7;
  localparam int IDX_W      = 6;
  localparam int COORD_W    = 16;
  localparam int FRAC_BITS  = 40;
  localparam int ACC_W      = 64;
  localparam logic [CNT_W-1:0] PC_RESET = CNT_W'(16);

  // Derived datapath widths
  localparam int NW        = $clog2(MAX_POINTS);    // n = count - 1
  localparam int DEN_W     = 3 * NW;                // n^3
  localparam int COEF_W    = COORD_W + 4;           // a, b, c
  localparam int BN_W      = COEF_W + NW + 1;       // b * n
  localparam int CN_W      = COEF_W + 2 * NW + 1;   // c * n^2
  localparam int MAG_W     = COORD_W + 2 * NW + 4;  // |numerator|
  localparam int NUM_W     = MAG_W + 1;             // signed numerator
  localparam int DIV_STEPS = MAG_W + FRAC_BITS;     // one quotient bit per step
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int INT_W     = ACC_W - FRAC_BITS + 1; // integer part plus round carry

  localparam logic [INT_W-1:0] COORD_MAXPOS = INT_W'((1 << (COORD_W - 1)) - 1);
  localparam logic [INT_W-1:0] COORD_NEGMAG = INT_W'(1 << (COORD_W - 1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_COEF,
    S_MULT,
    S_SUM,
    S_DIV,
    S_FIN,
    S_EMIT
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic          load;
    logic          coef;
    logic          mult;
    logic          sum;
    logic          div_step;
    logic          fin;
    logic          emit;
    logic          last;
    logic [NW-1:0] n;
    logic [NW-1:0] index;
  } dp_cmd_t;

  // Accumulator to coordinate: round half away from zero, saturate.
  function automatic logic [COORD_W-1:0] acc_to_coord(input logic [ACC_W-1:0] acc);
    logic             neg;
    logic [ACC_W-1:0] mag;
    logic [INT_W-1:0] q;
    logic [INT_W-1:0] q_neg;
    logic [COORD_W-1:0] res;
    neg   = acc[ACC_W-1];
    mag   = neg ? (ACC_W'(0) - acc) : acc;
    q     = {1'b0, mag[ACC_W-1:FRAC_BITS]} + INT_W'(mag[FRAC_BITS-1]);
    q_neg = INT_W'(0) - q;
    if (neg) begin
      res = (q > COORD_NEGMAG) ? COORD_NEGMAG[COORD_W-1:0] : q_neg[COORD_W-1:0];
    end else begin
      res = (q > COORD_MAXPOS) ? COORD_MAXPOS[COORD_W-1:0] : q[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cbfd_div_lane.sv */
// Bit-serial divider lane: round(mag * 2^FRAC_BITS / den), sign applied.
`default_nettype none

module cbfd_div_lane import cbfd_pkg::*; (
  input  logic             clk_i,
  input  logic             init_i,
  input  logic             step_i,
  input  logic [MAG_W-1:0] mag_i,
  input  logic             neg_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [ACC_W-1:0] res_o
);

  logic [MAG_W-1:0] dvd_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [ACC_W-1:0] quo_q, q_rnd;
  logic             neg_q;
  logic [DEN_W:0]   shifted, diff;
  logic             ge, round_up;

  always_comb begin
    shifted  = {rem_q, dvd_q[MAG_W-1]};
    diff     = shifted - {1'b0, den_i};
    ge       = shifted >= {1'b0, den_i};
    rem_d    = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    round_up = {rem_q, 1'b0} >= {1'b0, den_i};
    q_rnd    = quo_q + ACC_W'(round_up);
    res_o    = neg_q ? (ACC_W'(0) - q_rnd) : q_rnd;
  end

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      dvd_q <= mag_i;
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= neg_i;
    end else if (step_i) begin
      dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[ACC_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cbfd_dpath.sv */
// Datapath: coefficients, difference set-up, forward-difference accumulators.
`default_nettype none

module cbfd_dpath import cbfd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  input  logic signed [COORD_W-1:0] pt_i [4][3],
  output logic                      strobe_o,
  output logic signed [COORD_W-1:0] curve_o [3],
  output logic [IDX_W-1:0]          index_o,
  output logic                      last_o
);

  logic signed [COORD_W-1:0] p_q [4][3];
  logic [NW-1:0]             n_q;
  logic [2*NW-1:0]           n2_q;
  logic [DEN_W-1:0]          n3_q;
  logic signed [COEF_W-1:0]  a_q [3], b_q [3], c_q [3];
  logic signed [COEF_W-1:0]  a_d [3], b_d [3], c_d [3];
  logic signed [BN_W-1:0]    bn_q [3];
  logic signed [CN_W-1:0]    cn2_q [3];
  logic signed [NUM_W-1:0]   num [3][3];
  logic [MAG_W-1:0]          mag [3][3];
  logic                      neg [3][3];
  logic [ACC_W-1:0]          res [3][3];
  logic [ACC_W-1:0]          acc_q [3], d1_q [3], d2_q [3], d3_q [3];
  logic                      strobe_q;
  logic signed [COORD_W-1:0] curve_q [3];
  logic [IDX_W-1:0]          index_q;
  logic                      last_q;

  // Power-basis coefficients
  always_comb begin
    logic signed [COEF_W-1:0] e0, e1, e2, e3;
    for (int ax = 0; ax < 3; ax++) begin
      e0 = COEF_W'(p_q[0][ax]);
      e1 = COEF_W'(p_q[1][ax]);
      e2 = COEF_W'(p_q[2][ax]);
      e3 = COEF_W'(p_q[3][ax]);
      a_d[ax] = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
      b_d[ax] = (e0 <<< 1) + e0 - (e1 <<< 2) - (e1 <<< 1) + (e2 <<< 1) + e2;
      c_d[ax] = (e1 <<< 1) + e1 - (e0 <<< 1) - e0;
    end
  end

  // Numerators over n^3: first, second, third difference
  always_comb begin
    logic signed [NUM_W-1:0] ae, bne, cne, a6;
    for (int ax = 0; ax < 3; ax++) begin
      ae  = NUM_W'(a_q[ax]);
      bne = NUM_W'(bn_q[ax]);
      cne = NUM_W'(cn2_q[ax]);
      a6  = (ae <<< 2) + (ae <<< 1);
      num[ax][0] = ae + bne + cne;
      num[ax][1] = a6 + (bne <<< 1);
      num[ax][2] = a6;
      for (int k = 0; k < 3; k++) begin
        neg[ax][k] = num[ax][k][NUM_W-1];
        mag[ax][k] = neg[ax][k] ? MAG_W'(NUM_W'(0) - num[ax][k]) : MAG_W'(num[ax][k]);
      end
    end
  end

  for (genvar gx = 0; gx < 3; gx++) begin : g_axis
    for (genvar gk = 0; gk < 3; gk++) begin : g_diff
      cbfd_div_lane u_lane (
        .clk_i  (clk_i),
        .init_i (cmd_i.sum),
        .step_i (cmd_i.div_step),
        .mag_i  (mag[gx][gk]),
        .neg_i  (neg[gx][gk]),
        .den_i  (n3_q),
        .res_o  (res[gx][gk])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q <= pt_i;
      n_q <= cmd_i.n;
    end
    if (cmd_i.coef) begin
      n2_q <= n_q * n_q;
      for (int ax = 0; ax < 3; ax++) begin
        a_q[ax]   <= a_d[ax];
        b_q[ax]   <= b_d[ax];
        c_q[ax]   <= c_d[ax];
        acc_q[ax] <= ACC_W'(p_q[0][ax]) << FRAC_BITS;
      end
    end
    if (cmd_i.mult) begin
      n3_q <= n2_q * n_q;
      for (int ax = 0; ax < 3; ax++) begin
        bn_q[ax]  <= b_q[ax] * $signed({1'b0, n_q});
        cn2_q[ax] <= c_q[ax] * $signed({1'b0, n2_q});
      end
    end
    if (cmd_i.fin) begin
      for (int ax = 0; ax < 3; ax++) begin
        d1_q[ax] <= res[ax][0];
        d2_q[ax] <= res[ax][1];
        d3_q[ax] <= res[ax][2];
      end
    end
    if (cmd_i.emit) begin
      for (int ax = 0; ax < 3; ax++) begin
        curve_q[ax] <= acc_to_coord(acc_q[ax]);
        acc_q[ax]   <= acc_q[ax] + d1_q[ax];
        d1_q[ax]    <= d1_q[ax] + d2_q[ax];
        d2_q[ax]    <= d2_q[ax] + d3_q[ax];
      end
      index_q <= IDX_W'(cmd_i.index);
      last_q  <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  assign strobe_o = strobe_q;
  assign curve_o  = curve_q;
  assign index_o  = index_q;
  assign last_o   = last_q;

endmodule

`default_nettype wire

/* hw/rtl/cbfd_ctrl.sv */
// Sequencer: set-up phases, divider step count and point emission.
`default_nettype none

module cbfd_ctrl import cbfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             busy_o,
  output dp_cmd_t          cmd_o
);

  ctrl_state_e          state_q, state_d;
  logic [NW-1:0]        last_idx_q, last_idx_d;
  logic [NW-1:0]        pt_q, pt_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [CNT_W-1:0]     cnt_sat;
  logic [CNT_W-1:0]     cnt_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      last_idx_q <= '0;
      pt_q       <= '0;
      div_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      last_idx_q <= last_idx_d;
      pt_q       <= pt_d;
      div_cnt_q  <= div_cnt_d;
    end
  end

  always_comb begin
    cnt_sat    = (count_i > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_i;
    cnt_m1     = cnt_sat - CNT_W'(1);
    state_d    = state_q;
    last_idx_d = last_idx_q;
    pt_d       = pt_q;
    div_cnt_d  = div_cnt_q;
    cmd_o       = '0;
    cmd_o.n     = cnt_m1[NW-1:0];
    cmd_o.index = pt_q;
    cmd_o.last  = (pt_q == last_idx_q);
    case (state_q)
      S_IDLE: begin
        // a zero count takes the word and does nothing
        if (accept_i && (count_i != '0)) begin
          cmd_o.load = 1'b1;
          last_idx_d = cnt_m1[NW-1:0];
          state_d    = S_COEF;
        end
      end
      S_COEF: begin
        cmd_o.coef = 1'b1;
        pt_d       = '0;
        state_d    = (last_idx_q == '0) ? S_EMIT : S_MULT;
      end
      S_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        div_cnt_d = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + DIV_CNT_W'(1);
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (pt_q == last_idx_q) begin
          state_d = S_IDLE;
        end else begin
          pt_d = pt_q + NW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/cubic_bezier_forward_difference.sv */
// Set-up is dominated by the 72-step serial divide; a count of 1 skips the divide and emits P0.
// The block takes no new segment until the last point of the current one has been shown.
// After set-up, points come one per cycle; a count of zero takes the word and emits nothing.
// Reset (rst_ni low, async): sequencer idle, no strobe, point_count back to 16.
// The receiver cannot stall: each point is on the result ports for exactly one cycle.
`default_nettype none

module cubic_bezier_forward_difference import cbfd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command side
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] p0_x_i,
  input  logic signed [COORD_W-1:0] p0_y_i,
  input  logic signed [COORD_W-1:0] p0_z_i,
  input  logic signed [COORD_W-1:0] p1_x_i,
  input  logic signed [COORD_W-1:0] p1_y_i,
  input  logic signed [COORD_W-1:0] p1_z_i,
  input  logic signed [COORD_W-1:0] p2_x_i,
  input  logic signed [COORD_W-1:0] p2_y_i,
  input  logic signed [COORD_W-1:0] p2_z_i,
  input  logic signed [COORD_W-1:0] p3_x_i,
  input  logic signed [COORD_W-1:0] p3_y_i,
  input  logic signed [COORD_W-1:0] p3_z_i,
  // point_count register write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CNT_W-1:0]          cfg_data_i,
  // result side
  output logic                      result_strobe_o,
  output logic signed [COORD_W-1:0] curve_x_o,
  output logic signed [COORD_W-1:0] curve_y_o,
  output logic signed [COORD_W-1:0] curve_z_o,
  output logic [IDX_W-1:0]          point_index_o,
  output logic                      last_point_o
);

  logic [CNT_W-1:0]          point_count_q;
  logic                      accept;
  logic                      ctrl_busy;
  dp_cmd_t                   cmd;
  logic signed [COORD_W-1:0] pts [4][3];
  logic signed [COORD_W-1:0] curve [3];

  // Config word always taken; the user should write it only while idle (the block itself does
  // not enforce this), so no hazard with a segment in flight.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= PC_RESET;
    end else if (cfg_valid_i) begin
      point_count_q <= cfg_data_i;
    end
  end

  // Busy also covers the cycle that shows the final point, so a new
  // segment is never loaded while the sequencer still looks idle to it.
  assign busy   = ctrl_busy | result_strobe_o;
  assign accept = start & ~busy;

  assign pts[0] = '{p0_x_i, p0_y_i, p0_z_i};
  assign pts[1] = '{p1_x_i, p1_y_i, p1_z_i};
  assign pts[2] = '{p2_x_i, p2_y_i, p2_z_i};
  assign pts[3] = '{p3_x_i, p3_y_i, p3_z_i};

  // Sequencer: load -> coefficients -> products -> numerators -> serial divide (all nine
  // differences at once) -> round -> emit; a single point goes from coefficients straight to emit.
  cbfd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .count_i  (point_count_q),
    .busy_o   (ctrl_busy),
    .cmd_o    (cmd)
  );

  // Datapath: nine divider lanes and the 64-bit difference accumulators.
  cbfd_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .pt_i     (pts),
    .strobe_o (result_strobe_o),
    .curve_o  (curve),
    .index_o  (point_index_o),
    .last_o   (last_point_o)
  );

  assign curve_x_o = curve[0];
  assign curve_y_o = curve[1];
  assign curve_z_o = curve[2];

endmodule

`default_nettype wire

/* hw/rtl/cbfd_checker.sv */
// Port-level checks on the result word sequence, bound to the top level.
`default_nettype none

module cbfd_checker import cbfd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             busy,
  input logic             result_strobe_o,
  input logic [IDX_W-1:0] point_index_o,
  input logic             last_point_o
);

  // a result word is only shown while the block reports busy
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> busy)
    else $error("result word while not busy");

  // a segment's points run back to back with rising index
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !last_point_o |=>
      result_strobe_o && (point_index_o == IDX_W'($past(point_index_o) + IDX_W'(1))))
    else $error("point sequence broken");

  // the final point is followed by a gap
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_point_o |=> !result_strobe_o)
    else $error("word right after final point");

  // a segment starts at index zero
  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_strobe_o) |-> (point_index_o == '0))
    else $error("segment does not start at index zero");

endmodule

bind cubic_bezier_forward_difference cbfd_checker u_cbfd_checker (.*);

`default_nettype wire

/* tb/sv/cbfd_point_checker.sv */
// Scoreboard for the Bezier differencer: predicts the curve points of each segment and checks them.
`timescale 1ns / 100ps

module cbfd_point_checker import cbfd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [3:0][2:0][COORD_W-1:0] seg_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [CNT_W-1:0]             cfg_data_i,
  input  logic                         strobe_i,
  input  logic [COORD_W-1:0]           curve_x_i,
  input  logic [COORD_W-1:0]           curve_y_i,
  input  logic [COORD_W-1:0]           curve_z_i,
  input  logic [IDX_W-1:0]             point_index_i,
  input  logic                         last_point_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [IDX_W-1:0]   index;
    logic               last;
  } curve_pt_t;

  curve_pt_t        point_q[$];
  logic [CNT_W-1:0] count_reg = PC_RESET;
  int               mismatches = 0;

  // round(num * 2^FRAC_BITS / den), ties away from zero
  function automatic logic [ACC_W-1:0] scaled_ratio(input longint num, input logic [63:0] den);
    logic             neg;
    logic [63:0]      mag;
    logic [63:0]      whole;
    logic [63:0]      part;
    logic [63:0]      rest;
    logic [ACC_W-1:0] res;
    neg   = num < 0;
    mag   = neg ? 64'(-num) : 64'(num);
    whole = mag / den;
    part  = ((mag % den) << FRAC_BITS) / den;
    rest  = ((mag % den) << FRAC_BITS) % den;
    if (2 * rest >= den) part = part + 1;
    res = (whole << FRAC_BITS) + part;
    return neg ? (ACC_W'(0) - res) : res;
  endfunction

  // accumulator back to signed Q16.0, ties away from zero, clamped to the coordinate range
  function automatic logic [COORD_W-1:0] round_to_coord(input logic [ACC_W-1:0] acc);
    logic             neg;
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] q;
    logic [ACC_W-1:0] lim;
    neg = acc[ACC_W-1];
    mag = neg ? (ACC_W'(0) - acc) : acc;
    q   = (mag >> FRAC_BITS) + ACC_W'(mag[FRAC_BITS-1]);
    lim = neg ? (ACC_W'(1) << (COORD_W - 1)) : ((ACC_W'(1) << (COORD_W - 1)) - 1);
    if (q > lim) q = lim;
    q = neg ? (ACC_W'(0) - q) : q;
    return q[COORD_W-1:0];
  endfunction

  task automatic plan_segment(input logic [3:0][2:0][COORD_W-1:0] seg);
    int               cnt;
    longint           p0, p1, p2, p3, n, ca, cb, cc;
    logic [63:0]      n3;
    logic [ACC_W-1:0] pos[3];
    logic [ACC_W-1:0] d1[3];
    logic [ACC_W-1:0] d2[3];
    logic [ACC_W-1:0] d3[3];
    curve_pt_t        pt;
    cnt = int'(count_reg);
    if (cnt == 0) return;
    if (cnt > MAX_POINTS) cnt = MAX_POINTS;
    n  = cnt - 1;
    n3 = 64'(n * n * n);
    for (int ax = 0; ax < 3; ax++) begin
      p0 = longint'($signed(seg[0][ax]));
      p1 = longint'($signed(seg[1][ax]));
      p2 = longint'($signed(seg[2][ax]));
      p3 = longint'($signed(seg[3][ax]));
      pos[ax] = ACC_W'(p0 << FRAC_BITS);
      if (cnt > 1) begin
        ca = -p0 + 3 * p1 - 3 * p2 + p3;
        cb = 3 * p0 - 6 * p1 + 3 * p2;
        cc = 3 * p1 - 3 * p0;
        d1[ax] = scaled_ratio(ca + cb * n + cc * n * n, n3);
        d2[ax] = scaled_ratio(6 * ca + 2 * cb * n, n3);
        d3[ax] = scaled_ratio(6 * ca, n3);
      end else begin
        d1[ax] = '0;
        d2[ax] = '0;
        d3[ax] = '0;
      end
    end
    for (int k = 0; k < cnt; k++) begin
      pt.x     = round_to_coord(pos[0]);
      pt.y     = round_to_coord(pos[1]);
      pt.z     = round_to_coord(pos[2]);
      pt.index = IDX_W'(k);
      pt.last  = (k == cnt - 1);
      point_q.push_back(pt);
      for (int ax = 0; ax < 3; ax++) begin
        pos[ax] = pos[ax] + d1[ax];
        d1[ax]  = d1[ax] + d2[ax];
        d2[ax]  = d2[ax] + d3[ax];
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    curve_pt_t got;
    curve_pt_t want;
    if (!rst_ni) begin
      count_reg = PC_RESET;
      point_q.delete();
    end else begin
      got = {curve_x_i, curve_y_i, curve_z_i, point_index_i, last_point_i};
      if (strobe_i) begin
        if (point_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: unexpected point x=%0d y=%0d z=%0d idx=%0d last=%0b",
                     $signed(got.x), $signed(got.y), $signed(got.z), got.index, got.last);
        end else begin
          want = point_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"checker: point mismatch, expected x=%0d y=%0d z=%0d idx=%0d last=%0b,",
                        " got x=%0d y=%0d z=%0d idx=%0d last=%0b"},
                       $signed(want.x), $signed(want.y), $signed(want.z), want.index, want.last,
                       $signed(got.x), $signed(got.y), $signed(got.z), got.index, got.last);
          end
        end
      end
      // a word taken at this edge still sees the old point_count
      if (start_i && !busy_i) plan_segment(seg_i);
      if (cfg_valid_i && cfg_ready_i) count_reg = cfg_data_i;
    end
    mismatch_count_o <= mismatches;
    pending_o        <= point_q.size();
  end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the cubic Bezier forward differencer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb import cbfd_pkg::*; ();

  typedef logic [3:0][2:0][COORD_W-1:0] segment_t;

  // Drain wait after the last expected point; leaves room for a zero-count word still in flight.
  localparam int RESULT_DRAIN = 200;
  // Cycle limit for the whole run: all segments plus the drained phases must fit under it.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 150;

  localparam logic [COORD_W-1:0] C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] C_ZERO = '0;
  localparam logic [COORD_W-1:0] C_NEG1 = '1;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  segment_t         ctl_pt    = '0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;
  logic             result_strobe;
  logic [COORD_W-1:0] curve_x, curve_y, curve_z;
  logic [IDX_W-1:0] point_index;
  logic             last_point;
  int               mismatch_count;
  int               pending;
  int               cycles    = 0;
  bit               gaps_on   = 1'b1;

  always #4 clk_i = ~clk_i;

  // Hard stop in case the block hangs or drops points.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  cubic_bezier_forward_difference dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .p0_x_i         (ctl_pt[0][0]),
    .p0_y_i         (ctl_pt[0][1]),
    .p0_z_i         (ctl_pt[0][2]),
    .p1_x_i         (ctl_pt[1][0]),
    .p1_y_i         (ctl_pt[1][1]),
    .p1_z_i         (ctl_pt[1][2]),
    .p2_x_i         (ctl_pt[2][0]),
    .p2_y_i         (ctl_pt[2][1]),
    .p2_z_i         (ctl_pt[2][2]),
    .p3_x_i         (ctl_pt[3][0]),
    .p3_y_i         (ctl_pt[3][1]),
    .p3_z_i         (ctl_pt[3][2]),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .result_strobe_o(result_strobe),
    .curve_x_o      (curve_x),
    .curve_y_o      (curve_y),
    .curve_z_o      (curve_z),
    .point_index_o  (point_index),
    .last_point_o   (last_point)
  );

  cbfd_point_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .seg_i           (ctl_pt),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .strobe_i        (result_strobe),
    .curve_x_i       (curve_x),
    .curve_y_i       (curve_y),
    .curve_z_i       (curve_z),
    .point_index_i   (point_index),
    .last_point_i    (last_point),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  // Same value on all three axes of each control point.
  function automatic segment_t corner_segment(input logic [COORD_W-1:0] v0, v1, v2, v3);
    segment_t seg;
    for (int ax = 0; ax < 3; ax++) begin
      seg[0][ax] = v0;
      seg[1][ax] = v1;
      seg[2][ax] = v2;
      seg[3][ax] = v3;
    end
    return seg;
  endfunction

  // Mostly full-range words; some near the origin, some built from the range corners.
  function automatic segment_t random_segment();
    segment_t seg;
    int       style;
    style = $urandom_range(99);
    for (int k = 0; k < 4; k++) begin
      for (int ax = 0; ax < 3; ax++) begin
        if (style < 60) begin
          seg[k][ax] = COORD_W'($urandom);
        end else if (style < 85) begin
          seg[k][ax] = COORD_W'($urandom_range(128) - 64);
        end else begin
          case ($urandom_range(3))
            0:       seg[k][ax] = C_MIN;
            1:       seg[k][ax] = C_MAX;
            2:       seg[k][ax] = C_ZERO;
            default: seg[k][ax] = C_NEG1;
          endcase
        end
      end
    end
    return seg;
  endfunction

  // Hand one segment word to the block. start stays high after acceptance unless the
  // next call opens a gap, so back-to-back words never see start dropped and raised
  // in the same step.
  task automatic send_segment(input segment_t seg);
    while (gaps_on && $urandom_range(99) < 18) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    ctl_pt <= seg;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // point_count may only change with the block idle: all expected points seen, then
  // a drain long enough for a zero-count word that produced nothing.
  task automatic set_point_count(input logic [CNT_W-1:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (RESULT_DRAIN) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int               produced;
    int               words;
    int               pick;
    logic [CNT_W-1:0] cnt;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset count of 16, range corners and zigzag hulls
    send_segment(corner_segment(C_ZERO, C_ZERO, C_ZERO, C_ZERO));
    send_segment(corner_segment(C_MAX, C_MAX, C_MAX, C_MAX));
    send_segment(corner_segment(C_MIN, C_MIN, C_MIN, C_MIN));
    send_segment(corner_segment(C_MIN, C_MAX, C_MIN, C_MAX));
    send_segment(corner_segment(C_MAX, C_MIN, C_MAX, C_MIN));
    send_segment(corner_segment(C_ZERO, C_MAX, C_MIN, C_NEG1));

    // Single point: only P0 comes out, flagged last
    set_point_count(CNT_W'(1));
    send_segment(corner_segment(C_MIN, C_MAX, C_MIN, C_MAX));
    send_segment(random_segment());

    // Zero count: words are taken and nothing comes out
    set_point_count(CNT_W'(0));
    send_segment(random_segment());
    send_segment(random_segment());

    // Count above the maximum clamps to 64 points
    set_point_count(CNT_W'(127));
    send_segment(corner_segment(C_MAX, C_MIN, C_MAX, C_MIN));
    send_segment(random_segment());

    set_point_count(CNT_W'(MAX_POINTS));
    send_segment(corner_segment(C_MIN, C_MAX, C_MAX, C_MIN));
    send_segment(random_segment());

    // Two points: only the end points
    set_point_count(CNT_W'(2));
    send_segment(corner_segment(C_MIN, C_ZERO, C_ZERO, C_MAX));
    send_segment(random_segment());

    set_point_count(CNT_W'(3));
    send_segment(random_segment());
    send_segment(random_segment());

    // Random phases; mostly short segments, a few at or above the maximum.
    // Words 60..109 run with no sender gaps at all.
    produced = 0;
    while (produced < RANDOM_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 8)       cnt = CNT_W'(0);
      else if (pick < 18) cnt = CNT_W'(1);
      else if (pick < 30) cnt = CNT_W'($urandom_range(3, 2));
      else if (pick < 38) cnt = CNT_W'(MAX_POINTS);
      else if (pick < 44) cnt = CNT_W'($urandom_range(127, MAX_POINTS + 1));
      else                cnt = CNT_W'($urandom_range(24, 4));
      set_point_count(cnt);
      words = $urandom_range(14, 4);
      for (int w = 0; w < words; w++) begin
        gaps_on = !(produced >= 60 && produced < 110);
        send_segment(random_segment());
        produced++;
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (RESULT_DRAIN) @(posedge clk_i);

    if (mismatch_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
